[hdl/k_window_max_sum_dp_core_assert.svh]
// ---------------------------------------------------------------------------
// k_window_max_sum_dp_core assertion macros
// Clocked property helpers used by the core RTL file.
// ---------------------------------------------------------------------------
`ifndef K_WINDOW_MAX_SUM_DP_CORE_ASSERT_SVH
`define K_WINDOW_MAX_SUM_DP_CORE_ASSERT_SVH

// same-cycle implication
`define KWMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kwms assertion failed");

// next-cycle implication
`define KWMS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kwms assertion failed");

// fixed-delay implication
`define KWMS_ASSERT_DLY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("kwms assertion failed");

`endif

[hdl/k_wms_pkg.sv]
// ---------------------------------------------------------------------------
// k_wms_pkg
// Sizes, word types and register codes for the window max-sum core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package k_wms_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int MAX_COUNT   = 64;
    localparam int SAMPLE_BITS = 32;

    localparam int COLS      = MAX_COUNT + 1;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int POS_W     = $clog2(MAX_LEN + 1);
    localparam int SUM_W     = 42;
    localparam int LEN_W     = 11;
    localparam int CNT_W     = 7;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int DIFF_W    = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LEN   = 1'b0,
        CFG_WINDOW_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_in_word;

    typedef struct packed {
        logic signed [SUM_W-1:0] best_sum;
        logic                    feasible;
    } t_out_word;

    // one table entry: valid marks a reachable (row, count) pair
    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                    rd_en;
        logic [ADDR_W-1:0]       rd_addr;
        logic                    wr_en;
        logic [ADDR_W-1:0]       wr_addr;
        logic                    back_zero;
        logic                    back_ok;
        logic                    init;
        logic signed [SUM_W-1:0] wsum;
    } t_cell_ctl;

endpackage

[hdl/k_wms_ram.sv]
// ---------------------------------------------------------------------------
// k_wms_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module k_wms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[hdl/k_wms_cell.sv]
// ---------------------------------------------------------------------------
// k_wms_cell
// One table column: holds the previous row's entry and its own column
// memory, and hands the entry from window_len rows back to the next cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module k_wms_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  k_wms_pkg::t_cell_ctl  i_ctl,
    input  logic                  i_col0,
    input  logic                  i_sel,
    input  k_wms_pkg::t_entry     i_left,
    output k_wms_pkg::t_entry     o_back,
    output k_wms_pkg::t_entry     o_pick
);

    import k_wms_pkg::*;

    t_entry                  r_prev;
    t_entry                  w_bound;
    t_entry                  w_rd;
    t_entry                  n_new;
    logic signed [SUM_W-1:0] w_left_val;
    logic signed [SUM_W-1:0] w_prev_val;
    logic signed [SUM_W-1:0] w_cand;
    logic                    w_have0;
    logic                    w_have1;
    logic                    w_take;

    // row zero: only count zero is reachable, with sum zero
    assign w_bound = '{valid: i_col0, value: '0};

    always_comb begin
        w_left_val = i_left.value;
        w_prev_val = r_prev.value;
        w_cand     = w_left_val + i_ctl.wsum;
        w_have0    = r_prev.valid;
        w_have1    = i_ctl.back_ok & i_left.valid;
        w_take     = w_have1 & (~w_have0 | (w_cand > w_prev_val));
        n_new.valid = w_have0 | w_have1;
        if (w_take) begin
            n_new.value = w_cand;
        end else if (w_have0) begin
            n_new.value = w_prev_val;
        end else begin
            n_new.value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= w_bound;
        end else if (i_ctl.init) begin
            r_prev <= w_bound;
        end else if (i_ctl.wr_en) begin
            r_prev <= n_new;
        end
    end

    k_wms_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LEN)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_en),
        .i_waddr (i_ctl.wr_addr),
        .i_wdata (n_new),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_ctl.rd_addr),
        .o_rdata (w_rd)
    );

    assign o_back = i_ctl.back_zero ? w_bound : w_rd;
    assign o_pick = i_sel ? r_prev : '0;

endmodule

[hdl/k_window_max_sum_dp_core.sv]
// ---------------------------------------------------------------------------
// k_window_max_sum_dp_core
// Best total of window_count disjoint windows of window_len samples.
// ---------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one sample word (sample, last).
// Output channel: o_valid / i_stall carry one result word (best_sum,
// feasible), produced only for a word marked last.
// Config: i_cfg_we writes i_cfg_wdata to window_len (index 0) or
// window_count (index 1); values are latched at the first sample of a
// sequence.
// Steps per sample: accept, table read, window sum and cell update, plus
// a result pick for a word marked last; o_stall stays high from accept
// until the last step ends. The read-add-compare-write pass runs through
// the column memories; all 65 cells update in the same cycle.
// Result: the pick step registers a last word's result onto o_valid.
// Reset: position, running sum and cells return to the empty sequence,
// window_len = 1, window_count = 1. Memories need no clearing pass.
// Receiver stall: the result waits in the output register; samples keep
// being taken, and a further last word waits in its pick step, holding
// o_stall high, until that register drains.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "k_window_max_sum_dp_core_assert.svh"

module k_window_max_sum_dp_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  k_wms_pkg::t_in_word                i_data,
    output logic                               o_stall,
    output logic                               o_valid,
    output k_wms_pkg::t_out_word               o_data,
    input  logic                               i_stall,
    input  logic                               i_cfg_we,
    input  logic [k_wms_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [k_wms_pkg::CFG_W-1:0]        i_cfg_wdata
);

    import k_wms_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WSUM,
        S_CELL,
        S_PICK
    } t_state;

    t_state                  r_state;
    logic [LEN_W-1:0]        r_window_len;
    logic [CNT_W-1:0]        r_window_count;
    logic [LEN_W-1:0]        r_act_len;
    logic [CNT_W-1:0]        r_act_count;
    logic [POS_W-1:0]        r_pos;
    logic signed [SUM_W-1:0] r_run;
    logic [POS_W-1:0]        r_row;
    logic signed [SUM_W-1:0] r_s;
    logic signed [SUM_W-1:0] r_wsum;
    logic                    r_upd;
    logic                    r_last;
    logic                    r_back_zero;
    logic                    r_back_ok;
    logic                    r_out_valid;
    t_out_word               r_out;

    logic                    w_accept;
    logic                    w_load;
    logic [DIFF_W-1:0]       w_diff;
    logic signed [SUM_W-1:0] n_s;
    logic signed [SUM_W-1:0] w_pre_rd;
    logic signed [SUM_W-1:0] w_pre_back;
    logic                    w_len_ok;
    logic                    w_cnt_ok;
    logic [ENTRY_W-1:0]      w_pick_bits;
    t_entry                  w_pick;
    t_cell_ctl               w_ctl;
    logic [COLS-1:0]         w_sel;
    t_entry                  w_back [COLS];
    t_entry                  w_left [COLS];
    t_entry                  w_picks [COLS];

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_load   = (r_state == S_PICK) && (!r_out_valid || !i_stall);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    assign n_s    = r_run + {{(SUM_W-SAMPLE_BITS){i_data.sample[SAMPLE_BITS-1]}},
                             i_data.sample};
    assign w_diff = DIFF_W'(r_row) - DIFF_W'(r_act_len);
    assign w_pre_back = r_back_zero ? '0 : w_pre_rd;

    always_comb begin
        w_ctl.rd_en     = (r_state == S_READ);
        w_ctl.rd_addr   = w_diff[ADDR_W-1:0];
        w_ctl.wr_en     = (r_state == S_CELL) && r_upd;
        w_ctl.wr_addr   = r_row[ADDR_W-1:0];
        w_ctl.back_zero = r_back_zero;
        w_ctl.back_ok   = r_back_ok;
        w_ctl.init      = w_load;
        w_ctl.wsum      = r_wsum;
    end

    k_wms_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_LEN)
    ) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (w_ctl.wr_en),
        .i_waddr (w_ctl.wr_addr),
        .i_wdata (r_s),
        .i_re    (w_ctl.rd_en),
        .i_raddr (w_ctl.rd_addr),
        .o_rdata (w_pre_rd)
    );

    genvar g;
    generate
        for (g = 0; g < COLS; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_left[g] = '0;
            end else begin : g_rest
                assign w_left[g] = w_back[g-1];
            end
            assign w_sel[g] = (r_act_count == CNT_W'(g));

            k_wms_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_col0  (g == 0),
                .i_sel   (w_sel[g]),
                .i_left  (w_left[g]),
                .o_back  (w_back[g]),
                .o_pick  (w_picks[g])
            );
        end
    endgenerate

    always_comb begin
        w_pick_bits = '0;
        for (int j = 0; j < COLS; j++) begin
            w_pick_bits = w_pick_bits | w_picks[j];
        end
        w_pick = t_entry'(w_pick_bits);
    end

    assign w_len_ok = (r_act_len != '0) && (r_act_len <= LEN_W'(MAX_LEN));
    assign w_cnt_ok = (r_act_count <= CNT_W'(MAX_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_window_len   <= LEN_W'(1);
            r_window_count <= CNT_W'(1);
            r_act_len      <= '0;
            r_act_count    <= '0;
            r_pos          <= '0;
            r_run          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WINDOW_LEN: begin
                        r_window_len <= i_cfg_wdata[LEN_W-1:0];
                    end
                    CFG_WINDOW_COUNT: begin
                        r_window_count <= i_cfg_wdata[CNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (r_pos == '0) begin
                            r_act_len   <= r_window_len;
                            r_act_count <= r_window_count;
                        end
                        r_upd   <= (r_pos < POS_W'(MAX_LEN));
                        r_row   <= r_pos + POS_W'(1);
                        r_s     <= n_s;
                        r_last  <= i_data.last;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_back_zero <= (w_diff == '0);
                    r_back_ok   <= (DIFF_W'(r_row) >= DIFF_W'(r_act_len));
                    r_state     <= S_WSUM;
                end
                S_WSUM: begin
                    r_wsum  <= r_s - w_pre_back;
                    r_state <= S_CELL;
                end
                S_CELL: begin
                    if (r_upd) begin
                        r_run <= r_s;
                        r_pos <= r_row;
                    end
                    r_state <= r_last ? S_PICK : S_IDLE;
                end
                S_PICK: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        if (r_act_count == '0) begin
                            r_out.best_sum <= '0;
                            r_out.feasible <= 1'b1;
                        end else if (w_len_ok && w_cnt_ok && w_pick.valid) begin
                            r_out.best_sum <= w_pick.value;
                            r_out.feasible <= 1'b1;
                        end else begin
                            r_out.best_sum <= '0;
                            r_out.feasible <= 1'b0;
                        end
                        r_pos   <= '0;
                        r_run   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `KWMS_ASSERT_IMP(a_pos_bound, i_clk, i_rst_n, 1'b1, r_pos <= POS_W'(MAX_LEN))
    `KWMS_ASSERT_IMP(a_sel_onehot, i_clk, i_rst_n, 1'b1, $onehot0(w_sel))
    `KWMS_ASSERT_DLY(a_last_to_pick, i_clk, i_rst_n, w_accept && i_data.last, 4, r_state == S_PICK)
    `KWMS_ASSERT_NXT(a_load_clears, i_clk, i_rst_n, w_load, r_pos == '0 && r_run == '0 && r_out_valid)

endmodule

[sim/tb_k_window_max_sum_dp_core.sv]
// ---------------------------------------------------------------------------
// tb_k_window_max_sum_dp_core
// Self-checking bench for the windowed max-sum dynamic-programming core.
// A directed table covers sample extremes, zero and out-of-range window
// settings, sequences that are too short and a register write in the middle
// of a sequence. It is followed by random sequences under changing window
// settings, one of them longer than the prefix ring. Every accepted sample
// word runs through a local copy of the row-by-row table. Each result word
// is compared field by field with the oldest predicted result. Both
// handshakes idle at random, with one stretch that has no idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_k_window_max_sum_dp_core;
    import k_wms_pkg::*;

    localparam int     TBL_COLS     = MAX_COUNT + 1;
    localparam int     WORD_TARGET  = 1600;
    localparam int     LONG_SEQ     = MAX_LEN + 6;
    localparam int     SETTLE       = 12;
    localparam int     CALM_FROM    = 1300;
    localparam int     CALM_TO      = 1500;
    localparam longint LIMIT_CYCLES = 1000000;

    typedef enum {ROW_CFG, ROW_WORD} t_row_kind;

    typedef struct {
        t_row_kind               kind;
        t_cfg_idx                idx;
        int unsigned             value;
        logic [SAMPLE_BITS-1:0]  sample;
        logic                    last;
        bit                      typed;
        longint                  want_sum;
        bit                      want_feas;
    } t_plan_row;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_word         in_word   = '0;
    logic             in_stall;
    logic             out_valid;
    t_out_word        out_word;
    logic             rx_stall  = 1'b0;
    logic             cfg_we    = 1'b0;
    t_cfg_idx         cfg_idx   = CFG_WINDOW_LEN;
    logic [CFG_W-1:0] cfg_wdata = '0;

    k_window_max_sum_dp_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_data      (in_word),
        .o_stall     (in_stall),
        .o_valid     (out_valid),
        .o_data      (out_word),
        .i_stall     (rx_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    longint      prefix_mem [MAX_LEN];
    longint      best_mem [MAX_LEN * TBL_COLS];
    int unsigned seq_pos  = 0;
    longint      run_sum  = 0;
    int unsigned reg_len  = 1;
    int unsigned reg_cnt  = 1;
    int unsigned seq_len  = 0;
    int unsigned seq_cnt  = 0;

    t_out_word   pending_results [$];
    t_plan_row   plan [$];

    int          words_sent   = 0;
    int          seqs_done    = 0;
    int          results_seen = 0;
    int          feas_seen    = 0;
    int          reg_writes   = 0;
    int          mismatches   = 0;
    longint      cycles       = 0;

    function automatic bit idle_roll();
        if (words_sent >= CALM_FROM && words_sent < CALM_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 10;
    endfunction

    function automatic longint best_rd(int unsigned row, int unsigned j);
        if (row == 0)
            return 0;
        return best_mem[(row % MAX_LEN) * TBL_COLS + (j % TBL_COLS)];
    endfunction

    function automatic longint prefix_rd(int unsigned row);
        return (row == 0) ? 0 : prefix_mem[row % MAX_LEN];
    endfunction

    function automatic bit len_ok();
        return seq_len >= 1 && seq_len <= MAX_LEN;
    endfunction

    // one table row: keep the column, or close a window ending at row i
    function automatic void dp_fill_row(int unsigned i, longint s);
        longint      row_new [TBL_COLS];
        int unsigned n;
        int unsigned j;
        longint      v;
        longint      c;
        bit          have;
        n = (seq_cnt > MAX_COUNT) ? MAX_COUNT : seq_cnt;
        for (j = 0; j <= n; j++) begin
            have = 1'b0;
            v = 0;
            if (longint'(j) * seq_len <= longint'(i) - 1) begin
                v = best_rd(i - 1, j);
                have = 1'b1;
            end
            if (j >= 1 && i >= seq_len &&
                longint'(j - 1) * seq_len <= longint'(i - seq_len)) begin
                c = best_rd(i - seq_len, j - 1) + (s - prefix_rd(i - seq_len));
                if (!have || c > v)
                    v = c;
                have = 1'b1;
            end
            row_new[j] = have ? v : 0;
        end
        for (j = 0; j <= n; j++)
            best_mem[(i % MAX_LEN) * TBL_COLS + j] = row_new[j];
    endfunction

    function automatic bit window_dp_step(t_in_word w, output t_out_word res);
        longint      x;
        longint      s;
        longint      best;
        bit          feas;
        int unsigned i;
        x = longint'($signed(w.sample));
        best = 0;
        feas = 1'b0;
        res = '0;
        if (seq_pos == 0) begin
            seq_len = reg_len;
            seq_cnt = reg_cnt;
        end
        if (seq_pos < MAX_LEN) begin
            i = seq_pos + 1;
            s = run_sum + x;
            if (len_ok() && seq_cnt <= MAX_COUNT)
                dp_fill_row(i, s);
            prefix_mem[i % MAX_LEN] = s;
            run_sum = s;
            seq_pos = i;
        end
        if (!w.last)
            return 1'b0;
        if (seq_cnt == 0) begin
            feas = 1'b1;
        end else if (len_ok() && seq_cnt <= MAX_COUNT &&
                     longint'(seq_cnt) * seq_len <= longint'(seq_pos)) begin
            best = best_rd(seq_pos, seq_cnt);
            feas = 1'b1;
        end
        res.best_sum = best[SUM_W-1:0];
        res.feasible = feas;
        seq_pos = 0;
        run_sum = 0;
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2, 3: return $urandom;
            default: return SAMPLE_BITS'(int'($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    function automatic void plan_cfg(t_cfg_idx idx, int unsigned value);
        t_plan_row r;
        r = '{kind: ROW_CFG, idx: idx, value: value, sample: '0, last: 1'b0,
              typed: 1'b0, want_sum: 0, want_feas: 1'b0};
        plan.insert(plan.size(), r);
    endfunction

    function automatic void plan_word(longint sample, bit last);
        t_plan_row r;
        r = '{kind: ROW_WORD, idx: CFG_WINDOW_LEN, value: 0,
              sample: sample[SAMPLE_BITS-1:0], last: last,
              typed: 1'b0, want_sum: 0, want_feas: 1'b0};
        plan.insert(plan.size(), r);
    endfunction

    function automatic void plan_result(longint sample, longint sum, bit feas);
        t_plan_row r;
        r = '{kind: ROW_WORD, idx: CFG_WINDOW_LEN, value: 0,
              sample: sample[SAMPLE_BITS-1:0], last: 1'b1,
              typed: 1'b1, want_sum: sum, want_feas: feas};
        plan.insert(plan.size(), r);
    endfunction

    // returns right after the accepting edge, before any drive in that step
    task automatic send_word(t_in_word w, bit typed, longint want_sum, bit want_feas);
        t_out_word res;
        while (idle_roll()) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (in_stall);
        words_sent++;
        if (window_dp_step(w, res)) begin
            seqs_done++;
            if (typed) begin
                res.best_sum = want_sum[SUM_W-1:0];
                res.feasible = want_feas;
            end
            pending_results.insert(pending_results.size(), res);
        end
    endtask

    task automatic set_reg(t_cfg_idx idx, int unsigned value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_WINDOW_LEN)
            reg_len = value & 32'h7FF;
        else
            reg_cnt = value & 32'h7F;
        reg_writes++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n)
            rx_stall <= 1'b0;
        else
            rx_stall <= idle_roll();
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results still pending", $time,
                     pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_valid && !rx_stall) begin
            results_seen++;
            if (out_word.feasible)
                feas_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word: expected none, got sum %0d feasible %0b",
                         $time, $signed(out_word.best_sum), out_word.feasible);
            end else begin
                want = pending_results.pop_front();
                if (out_word.best_sum !== want.best_sum) begin
                    mismatches++;
                    $display("%0t: best_sum mismatch: expected %0d, got %0d", $time,
                             $signed(want.best_sum), $signed(out_word.best_sum));
                end
                if (out_word.feasible !== want.feasible) begin
                    mismatches++;
                    $display("%0t: feasible mismatch: expected %0b, got %0b", $time,
                             want.feasible, out_word.feasible);
                end
            end
        end
    end

    initial begin
        t_in_word    w;
        int unsigned len_v;
        int unsigned cnt_v;
        int          seqs;
        int          forced_len;
        int          base;
        int          n_words;
        bit          long_done;

        // after reset: window_len 1, window_count 1
        plan_result(32'sh7FFF_FFFF, 64'sd2147483647, 1'b1);
        plan_result(-64'sd2147483648, -64'sd2147483648, 1'b1);
        plan_word(5, 1'b0);
        plan_word(-3, 1'b0);
        plan_word(7, 1'b1);
        plan_cfg(CFG_WINDOW_COUNT, 0);
        plan_result(100, 0, 1'b1);
        plan_cfg(CFG_WINDOW_COUNT, 3);
        plan_word(1, 1'b0);
        plan_result(2, 0, 1'b0);
        plan_cfg(CFG_WINDOW_LEN, 0);
        plan_cfg(CFG_WINDOW_COUNT, 1);
        plan_result(9, 0, 1'b0);
        plan_cfg(CFG_WINDOW_COUNT, 0);
        plan_result(9, 0, 1'b1);
        plan_cfg(CFG_WINDOW_LEN, 2047);
        plan_cfg(CFG_WINDOW_COUNT, 1);
        plan_result(1, 0, 1'b0);
        plan_cfg(CFG_WINDOW_LEN, 2);
        plan_cfg(CFG_WINDOW_COUNT, MAX_COUNT + 1);
        plan_word(1, 1'b0);
        plan_result(2, 0, 1'b0);
        plan_cfg(CFG_WINDOW_COUNT, 2);
        plan_word(-1, 1'b0);
        plan_word(4, 1'b0);
        plan_word(6, 1'b0);
        plan_word(-2, 1'b0);
        plan_word(3, 1'b0);
        plan_word(3, 1'b1);
        // count changes mid-sequence; the latched count of 1 still applies
        plan_cfg(CFG_WINDOW_LEN, 1);
        plan_cfg(CFG_WINDOW_COUNT, 1);
        plan_word(3, 1'b0);
        plan_word(4, 1'b0);
        plan_cfg(CFG_WINDOW_COUNT, 2);
        plan_word(5, 1'b1);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                set_reg(plan[r].idx, plan[r].value);
            end else begin
                w.sample = plan[r].sample;
                w.last   = plan[r].last;
                send_word(w, plan[r].typed, plan[r].want_sum, plan[r].want_feas);
            end
        end

        long_done = 1'b0;
        while (words_sent < WORD_TARGET) begin
            forced_len = 0;
            seqs = $urandom_range(2, 5);
            if (!long_done && words_sent >= 200) begin
                // widest window, sequence runs past the ring depth
                long_done  = 1'b1;
                len_v      = MAX_LEN;
                cnt_v      = 1;
                seqs       = 1;
                forced_len = LONG_SEQ;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        len_v = 1;
                        cnt_v = $urandom_range(0, 1) ? MAX_COUNT : $urandom_range(40, MAX_COUNT - 1);
                    end
                    1: begin
                        len_v = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_LEN + 1, 2047);
                        cnt_v = $urandom_range(0, 2);
                    end
                    2: begin
                        len_v = $urandom_range(1, 4);
                        cnt_v = $urandom_range(MAX_COUNT + 1, 127);
                    end
                    default: begin
                        len_v = $urandom_range(1, 4);
                        cnt_v = $urandom_range(0, 5);
                    end
                endcase
            end
            set_reg(CFG_WINDOW_LEN, len_v);
            set_reg(CFG_WINDOW_COUNT, cnt_v);
            repeat (seqs) begin
                if (forced_len != 0) begin
                    n_words = forced_len;
                end else if (len_v >= 1 && len_v <= MAX_LEN && cnt_v <= MAX_COUNT) begin
                    base = cnt_v * len_v;
                    if (base > 1 && $urandom_range(0, 4) == 0)
                        n_words = $urandom_range(1, base - 1);
                    else
                        n_words = base + $urandom_range(0, 6);
                    if (n_words == 0)
                        n_words = 1;
                end else begin
                    n_words = $urandom_range(1, 8);
                end
                for (int k = 0; k < n_words; k++) begin
                    w.sample = rand_sample();
                    w.last   = (k == n_words - 1);
                    send_word(w, 1'b0, 0, 1'b0);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Ran %0d sample words in %0d sequences; %0d results checked, %0d feasible.",
                 words_sent, seqs_done, results_seen, feas_seen);
        $display("%0d register writes: zero, full and oversized windows, one ring overrun.",
                 reg_writes);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/k_wms_pkg.sv
hdl/k_wms_ram.sv
hdl/k_wms_cell.sv
hdl/k_window_max_sum_dp_core.sv
sim/tb_k_window_max_sum_dp_core.sv
